FILE: rtl/lpl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpl_pkg
// shared constants and types for the lru page list with pinning
// ----------------------------------------------------------------------------
package lpl_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int KEY_W = 64;
    localparam int POS_W = 4;

    typedef enum logic [1:0] {
        CMD_ACCESS = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_SETPIN = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_IGNORE = 2'd1,
        ST_NOVICT = 2'd2,
        ST_RANGE  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_TAKE_RD,
        S_TAKE_CAP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_APPEND,
        S_DONE
    } state_t;

endpackage
`default_nettype wire

FILE: rtl/lpl_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpl_req_if
// request channel: one command beat
// ----------------------------------------------------------------------------
interface lpl_req_if
    import lpl_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [1:0]       cmd;
    logic [KEY_W-1:0] page_key;
    logic [POS_W-1:0] position;
    logic             page_valid;
    logic             page_swapped;
    logic             page_pinned;

    modport source (
        output valid, cmd, page_key, position, page_valid, page_swapped, page_pinned,
        input  ready
    );
    modport sink (
        input  valid, cmd, page_key, position, page_valid, page_swapped, page_pinned,
        output ready
    );
endinterface
`default_nettype wire

FILE: rtl/lpl_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpl_rsp_if
// response channel: one result beat
// ----------------------------------------------------------------------------
interface lpl_rsp_if
    import lpl_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [1:0]       status;
    logic             evicted_flag;
    logic [KEY_W-1:0] evicted_key;
    logic [CNT_W-1:0] fill_count;

    modport source (
        output valid, status, evicted_flag, evicted_key, fill_count,
        input  ready
    );
    modport sink (
        input  valid, status, evicted_flag, evicted_key, fill_count,
        output ready
    );
endinterface
`default_nettype wire

FILE: rtl/lru_page_list_with_pinning.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lru_page_list_with_pinning
// ordered page key list in a ram, move to newest on hit, evict oldest unpinned
// ----------------------------------------------------------------------------
// a clear, ignored or out of range command goes straight to its result beat;
//   an access searches the listed entries oldest first, a removal reads the entry
//   and moves each later entry down one place, and an append writes the key last;
//   the longest path is a full miss that evicts the oldest entry
// one command at a time: a new command is accepted only in idle, after the last result beat is registered
// reset: list empty, all pin marks clear, no result pending; keys need no reset
module lru_page_list_with_pinning
    import lpl_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    lpl_req_if.sink  req,
    lpl_rsp_if.source rsp
);
    state_t           state_reg, state_next;
    cmd_t             cmd_reg, cmd_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic             pin_reg, pin_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEPTH-1:0] pins_reg, pins_next;
    logic             report_reg, report_next;
    logic             append_reg, append_next;
    status_t          status_reg, status_next;
    logic             evf_reg, evf_next;
    logic [KEY_W-1:0] evk_reg, evk_next;
    logic             ov_reg, ov_next;
    logic [1:0]       os_reg, os_next;
    logic             oef_reg, oef_next;
    logic [KEY_W-1:0] oek_reg, oek_next;
    logic [CNT_W-1:0] ofc_reg, ofc_next;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr, rd_addr;
    logic [KEY_W-1:0] wr_data, rd_data;
    logic             vic_found;
    logic [IDX_W-1:0] vic_idx;
    logic [CNT_W-1:0] idx_plus1, idx_plus2;

    lpl_key_ram #(.DATA_W(KEY_W), .ADDR_W(IDX_W)) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign idx_plus1 = {1'b0, idx_reg} + CNT_W'(1);
    assign idx_plus2 = {1'b0, idx_reg} + CNT_W'(2);

    // first unpinned entry, only used with a full list
    always_comb
    begin
        vic_found = 1'b0;
        vic_idx   = '0;
        for (int j = DEPTH - 1; j >= 0; j--)
        begin
            if (!pins_reg[j])
            begin
                vic_found = 1'b1;
                vic_idx   = IDX_W'(j);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            pins_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pins_reg  <= pins_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        key_reg    <= key_next;
        pin_reg    <= pin_next;
        idx_reg    <= idx_next;
        report_reg <= report_next;
        append_reg <= append_next;
        status_reg <= status_next;
        evf_reg    <= evf_next;
        evk_reg    <= evk_next;
        os_reg     <= os_next;
        oef_reg    <= oef_next;
        oek_reg    <= oek_next;
        ofc_reg    <= ofc_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        key_next    = key_reg;
        pin_next    = pin_reg;
        idx_next    = idx_reg;
        cnt_next    = cnt_reg;
        pins_next   = pins_reg;
        report_next = report_reg;
        append_next = append_reg;
        status_next = status_reg;
        evf_next    = evf_reg;
        evk_next    = evk_reg;
        ov_next     = ov_reg;
        os_next     = os_reg;
        oef_next    = oef_reg;
        oek_next    = oek_reg;
        ofc_next    = ofc_reg;
        wr_en       = 1'b0;
        wr_addr     = idx_reg;
        wr_data     = rd_data;
        rd_addr     = idx_reg;
        req.ready   = 1'b0;

        if (ov_reg && rsp.ready)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    cmd_next    = cmd_t'(req.cmd);
                    key_next    = req.page_key;
                    pin_next    = req.page_pinned;
                    idx_next    = '0;
                    status_next = ST_DONE;
                    evf_next    = 1'b0;
                    evk_next    = '0;
                    report_next = 1'b0;
                    append_next = 1'b0;
                    state_next  = S_DONE;
                    case (cmd_t'(req.cmd))
                        CMD_ACCESS:
                        begin
                            if (req.page_swapped || !req.page_valid)
                            begin
                                status_next = ST_IGNORE;
                            end
                            else if (cnt_reg == '0)
                            begin
                                state_next = S_APPEND;
                            end
                            else
                            begin
                                state_next = S_SRCH_RD;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (CNT_W'(req.position) >= cnt_reg)
                            begin
                                status_next = ST_RANGE;
                            end
                            else
                            begin
                                idx_next    = IDX_W'(req.position);
                                report_next = 1'b1;
                                state_next  = S_TAKE_RD;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            cnt_next  = '0;
                            pins_next = '0;
                        end
                        CMD_SETPIN:
                        begin
                            if (cnt_reg == '0)
                            begin
                                status_next = ST_IGNORE;
                            end
                            else
                            begin
                                state_next = S_SRCH_RD;
                            end
                        end
                        default:
                        begin
                            status_next = ST_IGNORE;
                        end
                    endcase
                end
            end
            S_SRCH_RD:
            begin
                state_next = S_SRCH_CMP;
            end
            S_SRCH_CMP:
            begin
                if (rd_data == key_reg)
                begin
                    if (cmd_reg == CMD_SETPIN)
                    begin
                        pins_next[idx_reg] = pin_reg;
                        state_next         = S_DONE;
                    end
                    else
                    begin
                        append_next = 1'b1;
                        state_next  = S_TAKE_RD;
                    end
                end
                else if (idx_plus1 < cnt_reg)
                begin
                    idx_next   = IDX_W'(idx_plus1);
                    state_next = S_SRCH_RD;
                end
                else if (cmd_reg == CMD_SETPIN)
                begin
                    status_next = ST_IGNORE;
                    state_next  = S_DONE;
                end
                else if (cnt_reg < CNT_W'(DEPTH))
                begin
                    state_next = S_APPEND;
                end
                else if (vic_found)
                begin
                    idx_next    = vic_idx;
                    report_next = 1'b1;
                    append_next = 1'b1;
                    state_next  = S_TAKE_RD;
                end
                else
                begin
                    status_next = ST_NOVICT;
                    state_next  = S_DONE;
                end
            end
            S_TAKE_RD:
            begin
                state_next = S_TAKE_CAP;
            end
            S_TAKE_CAP:
            begin
                evf_next = report_reg;
                evk_next = report_reg ? rd_data : '0;
                for (int j = 0; j < DEPTH; j++)
                begin
                    if (IDX_W'(j) >= idx_reg)
                    begin
                        pins_next[j] = (j + 1 < DEPTH) ? pins_reg[(j + 1) % DEPTH] : 1'b0;
                    end
                end
                if (idx_plus1 < cnt_reg)
                begin
                    rd_addr    = IDX_W'(idx_plus1);
                    state_next = S_SHIFT_WR;
                end
                else
                begin
                    cnt_next   = cnt_reg - CNT_W'(1);
                    state_next = append_reg ? S_APPEND : S_DONE;
                end
            end
            S_SHIFT_RD:
            begin
                rd_addr    = IDX_W'(idx_plus1);
                state_next = S_SHIFT_WR;
            end
            S_SHIFT_WR:
            begin
                wr_en    = 1'b1;
                wr_addr  = idx_reg;
                wr_data  = rd_data;
                idx_next = IDX_W'(idx_plus1);
                if (idx_plus2 < cnt_reg)
                begin
                    state_next = S_SHIFT_RD;
                end
                else
                begin
                    cnt_next   = cnt_reg - CNT_W'(1);
                    state_next = append_reg ? S_APPEND : S_DONE;
                end
            end
            S_APPEND:
            begin
                wr_en                           = 1'b1;
                wr_addr                         = cnt_reg[IDX_W-1:0];
                wr_data                         = key_reg;
                pins_next[cnt_reg[IDX_W-1:0]]   = pin_reg;
                cnt_next                        = cnt_reg + CNT_W'(1);
                state_next                      = S_DONE;
            end
            S_DONE:
            begin
                if (!ov_reg || rsp.ready)
                begin
                    ov_next    = 1'b1;
                    os_next    = status_reg;
                    oef_next   = evf_reg;
                    oek_next   = evk_reg;
                    ofc_next   = cnt_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rsp.valid        = ov_reg;
    assign rsp.status       = os_reg;
    assign rsp.evicted_flag = oef_reg;
    assign rsp.evicted_key  = oek_reg;
    assign rsp.fill_count   = ofc_reg;
endmodule
`default_nettype wire

FILE: rtl/lpl_key_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpl_key_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module lpl_key_ram #(
    parameter int DATA_W = 64,
    parameter int ADDR_W = 4
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);
    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

FILE: test/lpl_scoreboard.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lpl_scoreboard
// tracks the page list contents and checks every response beat against it
// ----------------------------------------------------------------------------
import lpl_pkg::*;

class lpl_scoreboard;

    typedef struct {
        status_t          status;
        logic             evicted_flag;
        logic [KEY_W-1:0] evicted_key;
        logic [CNT_W-1:0] fill_count;
    } rsp_t;

    logic [KEY_W-1:0] keys [DEPTH];
    logic             pins [DEPTH];
    int               count;
    rsp_t             pending [$];
    int               errors;
    int               checked;
    int               evictions;
    int               no_victim;

    function new();
        count = 0;
        errors = 0;
        checked = 0;
        evictions = 0;
        no_victim = 0;
        foreach (keys[i])
        begin
            keys[i] = '0;
            pins[i] = 1'b0;
        end
    endfunction

    function int find_key(logic [KEY_W-1:0] key);
        for (int i = 0; i < count; i++)
            if (keys[i] == key)
                return i;
        return -1;
    endfunction

    function logic [KEY_W-1:0] take_at(int idx);
        logic [KEY_W-1:0] k;
        k = keys[idx];
        for (int i = idx; i + 1 < count; i++)
        begin
            keys[i] = keys[i + 1];
            pins[i] = pins[i + 1];
        end
        count--;
        return k;
    endfunction

    function void append(logic [KEY_W-1:0] key, logic pin);
        if (count < DEPTH)
        begin
            keys[count] = key;
            pins[count] = pin;
            count++;
        end
    endfunction

    function void note_request(cmd_t cmd, logic [KEY_W-1:0] key, logic [POS_W-1:0] pos,
                               logic pv, logic ps, logic pp);
        rsp_t r;
        int   idx;
        r.status = ST_DONE;
        r.evicted_flag = 1'b0;
        r.evicted_key = '0;
        case (cmd)
            CMD_ACCESS:
            begin
                if (ps || !pv)
                    r.status = ST_IGNORE;
                else
                begin
                    idx = find_key(key);
                    if (idx >= 0)
                    begin
                        void'(take_at(idx));
                        append(key, pp);
                    end
                    else if (count < DEPTH)
                        append(key, pp);
                    else
                    begin
                        idx = -1;
                        for (int i = 0; i < count; i++)
                            if (!pins[i] && idx < 0)
                                idx = i;
                        if (idx < 0)
                        begin
                            r.status = ST_NOVICT;
                            no_victim++;
                        end
                        else
                        begin
                            r.evicted_key = take_at(idx);
                            r.evicted_flag = 1'b1;
                            evictions++;
                            append(key, pp);
                        end
                    end
                end
            end
            CMD_REMOVE:
            begin
                if (int'(pos) >= count)
                    r.status = ST_RANGE;
                else
                begin
                    r.evicted_key = take_at(int'(pos));
                    r.evicted_flag = 1'b1;
                end
            end
            CMD_CLEAR:
            begin
                count = 0;
                foreach (keys[i])
                begin
                    keys[i] = '0;
                    pins[i] = 1'b0;
                end
            end
            default:
            begin
                idx = find_key(key);
                if (idx >= 0)
                    pins[idx] = pp;
                else
                    r.status = ST_IGNORE;
            end
        endcase
        r.fill_count = CNT_W'(count);
        pending.push_back(r);
    endfunction

    function void check_result(logic [1:0] st, logic ef, logic [KEY_W-1:0] ek,
                               logic [CNT_W-1:0] fc);
        rsp_t r;
        checked++;
        if (pending.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("mismatch: unexpected response beat st=%0d", st);
            return;
        end
        r = pending.pop_front();
        if (st !== r.status || ef !== r.evicted_flag || ek !== r.evicted_key
            || fc !== r.fill_count)
        begin
            errors++;
            if (errors <= 10)
                $display("mismatch: exp st=%0d ef=%0b ek=%h fc=%0d got st=%0d ef=%0b ek=%h fc=%0d",
                         r.status, r.evicted_flag, r.evicted_key, r.fill_count,
                         st, ef, ek, fc);
        end
    endfunction
endclass

FILE: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives page list commands under several idle patterns and checks each
// response beat against a software copy of the list
// ----------------------------------------------------------------------------
module testbench;
    import lpl_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   send_idle = 0;
    int   recv_stall = 0;
    longint cycles = 0;
    lpl_scoreboard sb;
    logic [KEY_W-1:0] key_pool [8];

    lpl_req_if req ();
    lpl_rsp_if rsp ();

    lru_page_list_with_pinning i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    always #4 clk = ~clk;

    initial
    begin
        req.valid = 1'b0;
        req.cmd = '0;
        req.page_key = '0;
        req.position = '0;
        req.page_valid = 1'b0;
        req.page_swapped = 1'b0;
        req.page_pinned = 1'b0;
        rsp.ready = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout");
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp.valid && rsp.ready)
                sb.check_result(rsp.status, rsp.evicted_flag, rsp.evicted_key, rsp.fill_count);
            rsp.ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    task automatic send_beat(cmd_t cmd, logic [KEY_W-1:0] key, logic [POS_W-1:0] pos,
                             logic pv, logic ps, logic pp);
        while ($urandom_range(99) < send_idle)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid <= 1'b1;
        req.cmd <= cmd;
        req.page_key <= key;
        req.position <= pos;
        req.page_valid <= pv;
        req.page_swapped <= ps;
        req.page_pinned <= pp;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        sb.note_request(cmd, key, pos, pv, ps, pp);
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    task automatic random_beat();
        int               sel;
        logic [KEY_W-1:0] key;
        cmd_t             cmd;
        sel = $urandom_range(99);
        if (sel < 70)
            cmd = CMD_ACCESS;
        else if (sel < 82)
            cmd = CMD_REMOVE;
        else if (sel < 84)
            cmd = CMD_CLEAR;
        else
            cmd = CMD_SETPIN;
        if ($urandom_range(9) < 7)
            key = key_pool[$urandom_range(7)] + KEY_W'($urandom_range(15));
        else
            key = {$urandom, $urandom};
        send_beat(cmd, key, POS_W'($urandom), $urandom_range(9) != 0,
                  $urandom_range(9) == 0, $urandom_range(3) == 0);
    endtask

    initial
    begin
        sb = new();
        foreach (key_pool[i])
            key_pool[i] = {$urandom, $urandom};
        key_pool[0] = 64'h0101010101010101;
        key_pool[1] = '0;
        key_pool[2] = '1 - 64'd15;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_beat(CMD_REMOVE, '0, '0, 1'b1, 1'b0, 1'b0);
        send_beat(CMD_SETPIN, 64'h5, '0, 1'b1, 1'b0, 1'b1);
        send_beat(CMD_ACCESS, 64'h1, '0, 1'b0, 1'b0, 1'b0);
        send_beat(CMD_ACCESS, 64'h1, '0, 1'b1, 1'b1, 1'b0);
        for (int i = 0; i < DEPTH; i++)
            send_beat(CMD_ACCESS, (i == 0) ? '1 : KEY_W'(i), '0, 1'b1, 1'b0, 1'b1);
        send_beat(CMD_ACCESS, 64'h77, '0, 1'b1, 1'b0, 1'b0);
        send_beat(CMD_ACCESS, 64'h3, '0, 1'b1, 1'b0, 1'b1);
        send_beat(CMD_SETPIN, 64'h4, '0, 1'b1, 1'b0, 1'b0);
        send_beat(CMD_ACCESS, 64'h88, '0, 1'b1, 1'b0, 1'b0);
        send_beat(CMD_REMOVE, '0, 4'hf, 1'b1, 1'b0, 1'b0);
        send_beat(CMD_REMOVE, '0, 4'hf, 1'b1, 1'b0, 1'b0);
        send_beat(CMD_CLEAR, '0, '0, 1'b1, 1'b0, 1'b0);
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle = (ph == 1 || ph == 3) ? ((ph == 1) ? 60 : 17) : 0;
            recv_stall = (ph == 2 || ph == 3) ? ((ph == 2) ? 60 : 17) : 0;
            for (int n = 0; n < 160; n++)
                random_beat();
            drain();
        end
        send_idle = 0;
        recv_stall = 0;
        repeat (4 * DEPTH + 10) @(posedge clk);

        $display("checked %0d response beats, %0d evictions, %0d full-and-pinned refusals",
                 sb.checked, sb.evictions, sb.no_victim);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

FILE: files.f
rtl/lpl_pkg.sv
rtl/lpl_req_if.sv
rtl/lpl_rsp_if.sv
rtl/lpl_key_ram.sv
rtl/lru_page_list_with_pinning.sv
test/lpl_scoreboard.sv
test/testbench.sv
